@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/vpim_pkg.sv @@
`default_nettype none
package vpim_pkg;

  // Item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Write offsets
  localparam logic [4:0] REG_IRQ_EN    = 5'h00;
  localparam logic [4:0] REG_LATCH_WR  = 5'h01;
  localparam logic [4:0] REG_MUL_A     = 5'h02;
  localparam logic [4:0] REG_MUL_B     = 5'h03;
  localparam logic [4:0] REG_DIV_LO    = 5'h04;
  localparam logic [4:0] REG_DIV_HI    = 5'h05;
  localparam logic [4:0] REG_DIV_B     = 5'h06;
  localparam logic [4:0] REG_HTIME_LO  = 5'h07;
  localparam logic [4:0] REG_HTIME_HI  = 5'h08;
  localparam logic [4:0] REG_VTIME_LO  = 5'h09;
  localparam logic [4:0] REG_VTIME_HI  = 5'h0a;

  // Read offsets
  localparam logic [4:0] REG_NMI_FLAG  = 5'h10;
  localparam logic [4:0] REG_IRQ_FLAG  = 5'h11;
  localparam logic [4:0] REG_STATUS    = 5'h12;
  localparam logic [4:0] REG_LATCH_RD  = 5'h13;
  localparam logic [4:0] REG_QUO_LO    = 5'h14;
  localparam logic [4:0] REG_QUO_HI    = 5'h15;
  localparam logic [4:0] REG_PROD_LO   = 5'h16;
  localparam logic [4:0] REG_PROD_HI   = 5'h17;
  localparam logic [4:0] REG_PAD_LO    = 5'h18;
  localparam logic [4:0] REG_PAD_HI    = 5'h19;
  localparam logic [4:0] REG_ZERO_LO   = 5'h1a;
  localparam logic [4:0] REG_ZERO_HI   = 5'h1f;

  // Open-bus merge masks
  localparam logic [7:0] BUS_MASK_NMI    = 8'h70;
  localparam logic [7:0] BUS_MASK_IRQ    = 8'h7f;
  localparam logic [7:0] BUS_MASK_STATUS = 8'h3e;
  localparam logic [7:0] NMI_FLAG_VER    = 8'h02;

  // Beam positions
  localparam logic [8:0]  LINE_VBL     = 9'd225;
  localparam logic [8:0]  LINE_VBL_OS  = 9'd240;
  localparam logic [10:0] DOT_RENDER   = 11'd512;
  localparam logic [10:0] DOT_HDMA     = 11'd1024;
  localparam logic [10:0] DOT_GAP_LO   = 11'd536;
  localparam logic [10:0] DOT_GAP_HI   = 11'd576;
  localparam logic [10:0] DOT_STEP     = 11'd2;

  // Reset values
  localparam logic [7:0]  RST_MUL_A    = 8'hff;
  localparam logic [15:0] RST_PROD     = 16'hfe01;
  localparam logic [15:0] RST_DIVIDEND = 16'hffff;
  localparam logic [15:0] RST_QUO      = 16'h0101;
  localparam logic [8:0]  RST_MATCH    = 9'h1ff;
  localparam logic [15:0] QUO_DIV_ZERO = 16'hffff;

  // Divider
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
    logic [7:0]  remainder;
  } div_res_t;

  function automatic logic [15:0] bit_rev16(input logic [15:0] x);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = x[15 - i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vpim_div.sv @@
`default_nettype none
module vpim_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [15:0]       dividend,
  input  wire logic [7:0]        divisor,
  output vpim_pkg::div_res_t     res
);
  import vpim_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] step;
  logic [15:0]       quo;
  logic [7:0]        rem;
  logic [7:0]        dvsr;
  logic              done;

  logic [8:0] trial;
  logic [9:0] diff;
  logic       ge;

  // One restoring step: bring in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem, quo[15]};
    diff  = {1'b0, trial} - {2'b00, dvsr};
    ge    = !diff[9];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[14:0], ge};
      rem <= ge ? diff[7:0] : trial[7:0];
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule
`default_nettype wire

@@ hw/rtl/video_position_irq_and_math_registers_core.sv @@
`default_nettype none
// Beam position counter, timer IRQ and math registers. Every item (tick,
// register read, register write) is taken and its result sits
// in the output register from the next cycle; a new item is taken in the
// same cycle the previous result leaves. The exception is a write to the
// divisor register with a non-zero byte: the 16/8 divide runs on a
// restoring divider, one quotient bit per cycle, so the input stalls
// until the result is in the output register.
// Writes to the auto-joypad, NMI enable and ROM speed bits are taken but
// have no effect in this block; DMA start offsets are ignored.
module video_position_irq_and_math_registers_core #(
  parameter int DOTS_PER_LINE   = 1364,
  parameter int LINES_PER_FRAME = 262
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [4:0]  reg_offset,
  input  wire logic [7:0]  write_data,
  input  wire logic        overscan_on,
  input  wire logic        render_off,
  input  wire logic [15:0] pad_state,
  input  wire logic [7:0]  open_bus,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic             irq_pending,
  output logic             vblank_flag,
  output logic             nmi_flag,
  output logic             cpu_slot,
  output logic             hdma_init_pulse,
  output logic             vblank_start_pulse,
  output logic             render_pulse,
  output logic [8:0]       line_number,
  output logic             hdma_run_pulse,
  output logic             latch_pulse
);
  import vpim_pkg::*;

  localparam logic [10:0] DOTS_END  = 11'(DOTS_PER_LINE);
  localparam logic [8:0]  LINES_END = 9'(LINES_PER_FRAME);

  // State
  logic [10:0] dot_pos;
  logic [8:0]  line_pos;
  logic        in_vblank, in_nmi, in_irq;
  logic        h_irq_on, v_irq_on, latch_level;
  logic [7:0]  mul_operand;
  logic [15:0] mul_result, dividend, quotient;
  logic [8:0]  h_match, v_match;
  logic        div_wait;

  logic [10:0] dot_pos_next;
  logic [8:0]  line_pos_next;
  logic        in_vblank_next, in_nmi_next, in_irq_next;
  logic        h_irq_on_next, v_irq_on_next, latch_level_next;
  logic [7:0]  mul_operand_next;
  logic [15:0] mul_result_next, dividend_next, quotient_next;
  logic [8:0]  h_match_next, v_match_next;

  // Result fields of the current item
  logic [7:0]  rd_c;
  logic        slot_c, hinit_c, vstart_c, ren_c, hrun_c, lpulse_c;
  logic        div_start;

  logic        vhit, hhit;
  logic [10:0] dot_sum;
  logic [8:0]  line_sum;
  logic [15:0] pad_rev;

  logic        in_accept, out_accept;
  div_res_t    div_res;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = div_wait || (out_valid && out_stall);

  // Item decode and next state
  always_comb begin
    dot_pos_next     = dot_pos;
    line_pos_next    = line_pos;
    in_vblank_next   = in_vblank;
    in_nmi_next      = in_nmi;
    in_irq_next      = in_irq;
    h_irq_on_next    = h_irq_on;
    v_irq_on_next    = v_irq_on;
    latch_level_next = latch_level;
    mul_operand_next = mul_operand;
    mul_result_next  = mul_result;
    dividend_next    = dividend;
    quotient_next    = quotient;
    h_match_next     = h_match;
    v_match_next     = v_match;
    rd_c      = '0;
    slot_c    = 1'b0;
    hinit_c   = 1'b0;
    vstart_c  = 1'b0;
    ren_c     = 1'b0;
    hrun_c    = 1'b0;
    lpulse_c  = 1'b0;
    div_start = 1'b0;
    vhit      = ({1'b0, line_pos} == ({1'b0, v_match} + 10'd1));
    hhit      = (dot_pos == {h_match, 2'b00});
    dot_sum   = dot_pos + DOT_STEP;
    line_sum  = line_pos + 9'd1;
    pad_rev   = bit_rev16(pad_state);

    case (opcode)
      OP_TICK: begin
        slot_c = (dot_pos < DOT_GAP_LO) || (dot_pos >= DOT_GAP_HI);
        // timer IRQ match
        if (v_irq_on && h_irq_on) begin
          if (vhit && hhit) in_irq_next = 1'b1;
        end else if (v_irq_on) begin
          if (vhit && dot_pos == DOT_HDMA) in_irq_next = 1'b1;
        end else if (h_irq_on) begin
          if (hhit) in_irq_next = 1'b1;
        end
        // line events
        if (dot_pos == '0) begin
          if (line_pos == '0) begin
            in_vblank_next = 1'b0;
            in_nmi_next    = 1'b0;
            hinit_c        = 1'b1;
          end else if (line_pos == LINE_VBL) begin
            vstart_c = !overscan_on;
          end else if (line_pos == LINE_VBL_OS) begin
            vstart_c = !in_vblank;
          end
          if (vstart_c) begin
            in_vblank_next = 1'b1;
            in_nmi_next    = 1'b1;
          end
        end else if (dot_pos == DOT_RENDER) begin
          ren_c = !in_vblank && !render_off;
        end else if (dot_pos == DOT_HDMA) begin
          hrun_c = !in_vblank;
        end
        // advance beam
        if (dot_sum >= DOTS_END || dot_sum < DOT_STEP) begin
          dot_pos_next  = '0;
          line_pos_next = (line_sum >= LINES_END || line_sum == '0) ? '0 : line_sum;
        end else begin
          dot_pos_next = dot_sum;
        end
      end
      OP_READ: begin
        case (reg_offset)
          REG_NMI_FLAG: rd_c = NMI_FLAG_VER | {in_nmi, 7'd0} | (open_bus & BUS_MASK_NMI);
          REG_IRQ_FLAG: begin
            rd_c        = {in_irq, 7'd0} | (open_bus & BUS_MASK_IRQ);
            in_irq_next = 1'b0;
          end
          REG_STATUS:   rd_c = {in_vblank, (dot_pos >= DOT_HDMA), 6'd0}
                               | (open_bus & BUS_MASK_STATUS);
          REG_LATCH_RD: rd_c = {latch_level, 7'd0};
          REG_QUO_LO:   rd_c = quotient[7:0];
          REG_QUO_HI:   rd_c = quotient[15:8];
          REG_PROD_LO:  rd_c = mul_result[7:0];
          REG_PROD_HI:  rd_c = mul_result[15:8];
          REG_PAD_LO:   rd_c = pad_rev[7:0];
          REG_PAD_HI:   rd_c = pad_rev[15:8];
          default:      rd_c = (reg_offset inside {[REG_ZERO_LO:REG_ZERO_HI]}) ? '0 : open_bus;
        endcase
      end
      OP_WRITE: begin
        case (reg_offset)
          REG_IRQ_EN: begin
            h_irq_on_next = write_data[4];
            v_irq_on_next = write_data[5];
            if (!write_data[4] && !write_data[5]) in_irq_next = 1'b0;
          end
          REG_LATCH_WR: begin
            lpulse_c         = !write_data[7] && latch_level;
            latch_level_next = write_data[7];
          end
          REG_MUL_A:    mul_operand_next = write_data;
          REG_MUL_B:    mul_result_next  = {8'd0, mul_operand} * {8'd0, write_data};
          REG_DIV_LO:   dividend_next    = {dividend[15:8], write_data};
          REG_DIV_HI:   dividend_next    = {write_data, dividend[7:0]};
          REG_DIV_B: begin
            // zero divisor resolves at once; otherwise the divider runs
            if (write_data == '0) begin
              quotient_next   = QUO_DIV_ZERO;
              mul_result_next = dividend;
            end else begin
              div_start = 1'b1;
            end
          end
          REG_HTIME_LO: h_match_next = {h_match[8], write_data};
          REG_HTIME_HI: h_match_next = {write_data[0], h_match[7:0]};
          REG_VTIME_LO: v_match_next = {v_match[8], write_data};
          REG_VTIME_HI: v_match_next = {write_data[0], v_match[7:0]};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Divider
  vpim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept && div_start),
    .dividend (dividend),
    .divisor  (write_data),
    .res      (div_res)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_pos     <= '0;
      line_pos    <= '0;
      in_vblank   <= 1'b0;
      in_nmi      <= 1'b0;
      in_irq      <= 1'b0;
      h_irq_on    <= 1'b0;
      v_irq_on    <= 1'b0;
      latch_level <= 1'b0;
      mul_operand <= RST_MUL_A;
      mul_result  <= RST_PROD;
      dividend    <= RST_DIVIDEND;
      quotient    <= RST_QUO;
      h_match     <= RST_MATCH;
      v_match     <= RST_MATCH;
      div_wait    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_accept) begin
        dot_pos     <= dot_pos_next;
        line_pos    <= line_pos_next;
        in_vblank   <= in_vblank_next;
        in_nmi      <= in_nmi_next;
        in_irq      <= in_irq_next;
        h_irq_on    <= h_irq_on_next;
        v_irq_on    <= v_irq_on_next;
        latch_level <= latch_level_next;
        mul_operand <= mul_operand_next;
        mul_result  <= mul_result_next;
        dividend    <= dividend_next;
        quotient    <= quotient_next;
        h_match     <= h_match_next;
        v_match     <= v_match_next;
        div_wait    <= div_start;
        out_valid   <= !div_start;
      end else if (div_res.done) begin
        quotient   <= div_res.quotient;
        mul_result <= {8'd0, div_res.remainder};
        div_wait   <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data          <= rd_c;
      irq_pending        <= in_irq_next;
      vblank_flag        <= in_vblank_next;
      nmi_flag           <= in_nmi_next;
      cpu_slot           <= slot_c;
      hdma_init_pulse    <= hinit_c;
      vblank_start_pulse <= vstart_c;
      render_pulse       <= ren_c;
      line_number        <= line_pos;
      hdma_run_pulse     <= hrun_c;
      latch_pulse        <= lpulse_c;
    end
  end

  `include "assert_macros.svh"

  // A divide in flight holds the input and has no result shown yet
  `ASSERT_IMPLIES(a_div_holds_input, div_wait, in_stall && !out_valid)
  `ASSERT_NEXT(a_div_launch, in_accept && div_start, div_wait)
  `ASSERT_IMPLIES(a_dot_range, 1'b1, dot_pos < DOTS_END)
  `ASSERT_IMPLIES(a_line_range, 1'b1, line_pos < LINES_END)

endmodule
`default_nettype wire

@@ sim/vpim_result_checker.sv @@
module vpim_result_checker #(
  parameter int DOTS_PER_LINE   = 1364,
  parameter int LINES_PER_FRAME = 262
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [4:0]  reg_offset,
  input  logic [7:0]  write_data,
  input  logic        overscan_on,
  input  logic        render_off,
  input  logic [15:0] pad_state,
  input  logic [7:0]  open_bus,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_data,
  input  logic        irq_pending,
  input  logic        vblank_flag,
  input  logic        nmi_flag,
  input  logic        cpu_slot,
  input  logic        hdma_init_pulse,
  input  logic        vblank_start_pulse,
  input  logic        render_pulse,
  input  logic [8:0]  line_number,
  input  logic        hdma_run_pulse,
  input  logic        latch_pulse,
  input  logic        run_done,
  output int          fail_count,
  output int          due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import vpim_pkg::*;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic       vbl;
    logic       nmi;
    logic       slot;
    logic       hinit;
    logic       vstart;
    logic       ren;
    logic [8:0] line;
    logic       hrun;
    logic       lpulse;
  } beam_result_t;

  // Shadow copy of the block state
  logic [10:0] beam_dot;
  logic [8:0]  beam_line;
  logic        vbl_active, nmi_latched, irq_flag;
  logic        h_irq_en, v_irq_en, latch_bit;
  logic [7:0]  mul_a;
  logic [15:0] product, dividend_r, quot;
  logic [8:0]  h_time, v_time;

  beam_result_t due_results[$];
  beam_result_t want_r, next_r;
  int errors = 0;
  int results_seen = 0;
  logic leftovers_checked;

  function automatic logic [15:0] mirror_pad(input logic [15:0] x);
    logic [15:0] m;
    for (int i = 0; i < 16; i++) m[15 - i] = x[i];
    return m;
  endfunction

  // Prints one line per mismatch and counts it
  task automatic note_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      note_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                              results_seen, name, got, want));
  endtask

  // Works out the result of one item and updates the shadow state
  task automatic compute_item_result(
    input  logic [1:0]  op,
    input  logic [4:0]  off,
    input  logic [7:0]  wd,
    input  logic        os,
    input  logic        ro,
    input  logic [15:0] pad,
    input  logic [7:0]  bus,
    output beam_result_t r
  );
    logic        vhit, hhit;
    logic [10:0] next_dot;
    logic [8:0]  next_line;
    logic [15:0] pad_rev;
    r = '0;
    r.line = beam_line;
    pad_rev = mirror_pad(pad);
    case (op)
      OP_TICK: begin
        vhit = ({1'b0, beam_line} == {1'b0, v_time} + 10'd1);
        hhit = (beam_dot == {h_time, 2'b00});
        r.slot = (beam_dot < DOT_GAP_LO) || (beam_dot >= DOT_GAP_HI);
        // timer interrupt match
        if (v_irq_en && h_irq_en) begin
          if (vhit && hhit) irq_flag = 1'b1;
        end else if (v_irq_en) begin
          if (vhit && beam_dot == DOT_HDMA) irq_flag = 1'b1;
        end else if (h_irq_en) begin
          if (hhit) irq_flag = 1'b1;
        end
        // line events
        if (beam_dot == '0) begin
          if (beam_line == '0) begin
            vbl_active  = 1'b0;
            nmi_latched = 1'b0;
            r.hinit     = 1'b1;
          end else if (beam_line == LINE_VBL) begin
            r.vstart = !os;
          end else if (beam_line == LINE_VBL_OS) begin
            r.vstart = !vbl_active;
          end
          if (r.vstart) begin
            vbl_active  = 1'b1;
            nmi_latched = 1'b1;
          end
        end else if (beam_dot == DOT_RENDER) begin
          r.ren = !vbl_active && !ro;
        end else if (beam_dot == DOT_HDMA) begin
          r.hrun = !vbl_active;
        end
        // advance the beam, wrapping into lines and frames
        next_dot = beam_dot + DOT_STEP;
        if (next_dot >= DOTS_PER_LINE || next_dot < DOT_STEP) begin
          beam_dot  = '0;
          next_line = beam_line + 9'd1;
          beam_line = (next_line >= LINES_PER_FRAME) ? 9'd0 : next_line;
        end else begin
          beam_dot = next_dot;
        end
      end
      OP_READ: begin
        case (off)
          REG_NMI_FLAG: r.rd = NMI_FLAG_VER | {nmi_latched, 7'd0} | (bus & BUS_MASK_NMI);
          REG_IRQ_FLAG: begin
            r.rd = {irq_flag, 7'd0} | (bus & BUS_MASK_IRQ);
            irq_flag = 1'b0;
          end
          REG_STATUS: begin
            r.rd = {vbl_active, beam_dot >= DOT_HDMA, 6'd0} | (bus & BUS_MASK_STATUS);
          end
          REG_LATCH_RD: r.rd = {latch_bit, 7'd0};
          REG_QUO_LO:   r.rd = quot[7:0];
          REG_QUO_HI:   r.rd = quot[15:8];
          REG_PROD_LO:  r.rd = product[7:0];
          REG_PROD_HI:  r.rd = product[15:8];
          REG_PAD_LO:   r.rd = pad_rev[7:0];
          REG_PAD_HI:   r.rd = pad_rev[15:8];
          // zero above the pad registers, open bus below the status block
          default:      r.rd = (off >= REG_ZERO_LO) ? 8'h00 : bus;
        endcase
      end
      OP_WRITE: begin
        case (off)
          REG_IRQ_EN: begin
            h_irq_en = wd[4];
            v_irq_en = wd[5];
            if (!wd[4] && !wd[5]) irq_flag = 1'b0;
          end
          REG_LATCH_WR: begin
            r.lpulse  = !wd[7] && latch_bit;
            latch_bit = wd[7];
          end
          REG_MUL_A:    mul_a = wd;
          REG_MUL_B:    product = {8'd0, mul_a} * {8'd0, wd};
          REG_DIV_LO:   dividend_r[7:0] = wd;
          REG_DIV_HI:   dividend_r[15:8] = wd;
          REG_DIV_B: begin
            // division by zero leaves the dividend as remainder
            if (wd == '0) begin
              quot    = QUO_DIV_ZERO;
              product = dividend_r;
            end else begin
              quot    = dividend_r / {8'd0, wd};
              product = dividend_r % {8'd0, wd};
            end
          end
          REG_HTIME_LO: h_time[7:0] = wd;
          REG_HTIME_HI: h_time[8] = wd[0];
          REG_VTIME_LO: v_time[7:0] = wd;
          REG_VTIME_HI: v_time[8] = wd[0];
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq = irq_flag;
    r.vbl = vbl_active;
    r.nmi = nmi_latched;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      beam_dot          = '0;
      beam_line         = '0;
      vbl_active        = 1'b0;
      nmi_latched       = 1'b0;
      irq_flag          = 1'b0;
      h_irq_en          = 1'b0;
      v_irq_en          = 1'b0;
      latch_bit         = 1'b0;
      mul_a             = RST_MUL_A;
      product           = RST_PROD;
      dividend_r        = RST_DIVIDEND;
      quot              = RST_QUO;
      h_time            = RST_MATCH;
      v_time            = RST_MATCH;
      due_results.delete();
      leftovers_checked <= 1'b0;
      due_count         <= 0;
    end else begin
      // compare each result with the oldest item outstanding
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with no item outstanding",
                                  results_seen));
        end else begin
          want_r = due_results.pop_front();
          check_field("read_data", int'(read_data), int'(want_r.rd));
          check_field("irq_pending", int'(irq_pending), int'(want_r.irq));
          check_field("vblank_flag", int'(vblank_flag), int'(want_r.vbl));
          check_field("nmi_flag", int'(nmi_flag), int'(want_r.nmi));
          check_field("cpu_slot", int'(cpu_slot), int'(want_r.slot));
          check_field("hdma_init_pulse", int'(hdma_init_pulse), int'(want_r.hinit));
          check_field("vblank_start_pulse", int'(vblank_start_pulse),
                      int'(want_r.vstart));
          check_field("render_pulse", int'(render_pulse), int'(want_r.ren));
          check_field("line_number", int'(line_number), int'(want_r.line));
          check_field("hdma_run_pulse", int'(hdma_run_pulse), int'(want_r.hrun));
          check_field("latch_pulse", int'(latch_pulse), int'(want_r.lpulse));
        end
      end
      if (in_valid && !in_stall) begin
        compute_item_result(opcode, reg_offset, write_data, overscan_on, render_off,
                            pad_state, open_bus, next_r);
        due_results.push_back(next_r);
      end
      if (run_done && !leftovers_checked) begin
        if (due_results.size() != 0)
          note_mismatch($sformatf("%0d results never arrived", due_results.size()));
        leftovers_checked <= 1'b1;
      end
      due_count <= due_results.size();
    end
    fail_count <= errors;
  end

endmodule

@@ sim/tb_video_position_irq_and_math_registers_core.sv @@
module tb_video_position_irq_and_math_registers_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vpim_pkg::*;

  localparam int DOTS_PER_LINE   = 1364;
  localparam int LINES_PER_FRAME = 262;
  localparam int PHASE_ITEMS     = 550;
  localparam int QUIET_LIMIT     = 2000;

  // codes with no name in the package
  localparam logic [1:0] OP_SPARE       = 2'd3;
  localparam logic [4:0] REG_DMA_START  = 5'h0b;
  localparam logic [4:0] REG_ROM_SPEED  = 5'h0d;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_TICK;
  logic [4:0]  reg_offset = '0;
  logic [7:0]  write_data = '0;
  logic        overscan_on = 1'b0;
  logic        render_off = 1'b0;
  logic [15:0] pad_state = '0;
  logic [7:0]  open_bus = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        irq_pending, vblank_flag, nmi_flag, cpu_slot;
  logic        hdma_init_pulse, vblank_start_pulse, render_pulse;
  logic [8:0]  line_number;
  logic        hdma_run_pulse, latch_pulse;
  logic        run_done = 1'b0;
  int          fail_count, due_count;

  int tx_idle_pct = 25;
  int rx_idle_pct = 80;
  int os_pct = 50;
  int ro_pct = 50;
  int items_sent = 0, ticks_sent = 0, reads_sent = 0, writes_sent = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  video_position_irq_and_math_registers_core #(
    .DOTS_PER_LINE  (DOTS_PER_LINE),
    .LINES_PER_FRAME(LINES_PER_FRAME)
  ) DUT (.*);

  vpim_result_checker #(
    .DOTS_PER_LINE  (DOTS_PER_LINE),
    .LINES_PER_FRAME(LINES_PER_FRAME)
  ) u_checker (.*);

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // Offers one item, with a random gap first, and waits for it to be taken
  task automatic send_item(input logic [1:0] op, input logic [4:0] off,
                           input logic [7:0] wd, input logic [15:0] pad,
                           input logic [7:0] bus);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    reg_offset  <= off;
    write_data  <= wd;
    pad_state   <= pad;
    open_bus    <= bus;
    overscan_on <= ($urandom_range(99) < os_pct);
    render_off  <= ($urandom_range(99) < ro_pct);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (op)
      OP_TICK:  ticks_sent++;
      OP_READ:  reads_sent++;
      OP_WRITE: writes_sent++;
      default: ;
    endcase
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 5'(rand_byte()), rand_byte(), rand_word(), rand_byte());
  endtask

  // Holds the sender off until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // One random sequence: mostly well-formed register traffic, some noise
  task automatic run_sequence(input int first_kind);
    int kind;
    logic [8:0] h, v;
    kind = $urandom_range(9, first_kind);
    case (kind)
      0, 1, 2: repeat ($urandom_range(24, 1)) send_tick();
      3: begin
        send_item(OP_WRITE, REG_MUL_A, rand_byte(), rand_word(), rand_byte());
        send_item(OP_WRITE, REG_MUL_B, rand_byte(), rand_word(), rand_byte());
        send_item(OP_READ, REG_PROD_LO, rand_byte(), rand_word(), rand_byte());
        send_item(OP_READ, REG_PROD_HI, rand_byte(), rand_word(), rand_byte());
      end
      4: begin
        send_item(OP_WRITE, REG_DIV_LO, rand_byte(), rand_word(), rand_byte());
        send_item(OP_WRITE, REG_DIV_HI, rand_byte(), rand_word(), rand_byte());
        send_item(OP_WRITE, REG_DIV_B, ($urandom_range(5) == 0) ? 8'h00 : rand_byte(),
                  rand_word(), rand_byte());
        send_item(OP_READ, REG_QUO_LO, rand_byte(), rand_word(), rand_byte());
        send_item(OP_READ, REG_QUO_HI, rand_byte(), rand_word(), rand_byte());
        send_item(OP_READ, REG_PROD_LO, rand_byte(), rand_word(), rand_byte());
        send_item(OP_READ, REG_PROD_HI, rand_byte(), rand_word(), rand_byte());
      end
      5: begin
        // timer set-up, mostly with match points the beam can reach
        h = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(340));
        v = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(LINES_PER_FRAME - 2));
        send_item(OP_WRITE, REG_HTIME_LO, h[7:0], rand_word(), rand_byte());
        send_item(OP_WRITE, REG_HTIME_HI, {7'($urandom), h[8]}, rand_word(), rand_byte());
        send_item(OP_WRITE, REG_VTIME_LO, v[7:0], rand_word(), rand_byte());
        send_item(OP_WRITE, REG_VTIME_HI, {7'($urandom), v[8]}, rand_word(), rand_byte());
        send_item(OP_WRITE, REG_IRQ_EN, rand_byte(), rand_word(), rand_byte());
      end
      6: repeat (2)
        send_item(OP_READ, 5'($urandom_range(REG_LATCH_RD, REG_NMI_FLAG)), rand_byte(),
                  rand_word(), rand_byte());
      7: begin
        send_item(OP_WRITE, REG_LATCH_WR, {1'b1, 7'($urandom)}, rand_word(), rand_byte());
        send_item(OP_READ, REG_LATCH_RD, rand_byte(), rand_word(), rand_byte());
        send_item(OP_WRITE, REG_LATCH_WR, rand_byte(), rand_word(), rand_byte());
      end
      8: begin
        send_item(OP_READ, REG_PAD_LO, rand_byte(), rand_word(), rand_byte());
        send_item(OP_READ, REG_PAD_HI, rand_byte(), rand_word(), rand_byte());
      end
      default: repeat ($urandom_range(3, 1))
        send_item(2'($urandom), 5'($urandom), rand_byte(), rand_word(), rand_byte());
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, field extremes, every opcode and the odd cases
    send_item(OP_TICK, 5'h00, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_NMI_FLAG, 8'h00, 16'h0000, 8'hff);
    send_item(OP_READ, REG_IRQ_FLAG, 8'h00, 16'h0000, 8'hff);
    send_item(OP_READ, REG_STATUS, 8'h00, 16'hffff, 8'hff);
    send_item(OP_READ, REG_LATCH_RD, 8'hff, 16'hffff, 8'hff);
    send_item(OP_READ, REG_QUO_LO, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_QUO_HI, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_PROD_LO, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_PROD_HI, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_PAD_LO, 8'h00, 16'h00ff, 8'h00);
    send_item(OP_READ, REG_PAD_HI, 8'h00, 16'h00ff, 8'h00);
    send_item(OP_READ, REG_ZERO_HI, 8'hff, 16'hffff, 8'hff);
    send_item(OP_READ, REG_IRQ_EN, 8'h00, 16'h0000, 8'hff);
    send_item(OP_WRITE, REG_MUL_A, 8'hff, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_MUL_B, 8'hff, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_DIV_LO, 8'h34, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_DIV_HI, 8'h12, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_DIV_B, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_QUO_HI, 8'h00, 16'h0000, 8'h00);
    send_item(OP_READ, REG_PROD_LO, 8'h00, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_DIV_B, 8'hff, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_LATCH_WR, 8'h80, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_LATCH_WR, 8'h00, 16'h0000, 8'h00);
    send_item(OP_SPARE, 5'h1f, 8'hff, 16'hffff, 8'hff);
    send_item(OP_WRITE, REG_ROM_SPEED, 8'h01, 16'h0000, 8'h00);
    send_item(OP_WRITE, REG_DMA_START, 8'hff, 16'h0000, 8'h00);
    drain_results();

    // Random traffic under three idle profiles
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 25 : (p == 1) ? 80 : 0;
      rx_idle_pct <= (p == 0) ? 80 : (p == 1) ? 25 : 0;
      while (items_sent < PHASE_ITEMS * (p + 1)) begin
        run_sequence(0);
        if ($urandom_range(39) == 0) drain_results();
      end
      drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Drove %0d items: %0d ticks, %0d reads, %0d writes, rest spare opcode",
             items_sent, ticks_sent, reads_sent, writes_sent);
    $display("Directed extremes, then random ticks and register traffic in three idle profiles");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/vpim_pkg.sv
hw/rtl/vpim_div.sv
hw/rtl/video_position_irq_and_math_registers_core.sv
sim/vpim_result_checker.sv
sim/tb_video_position_irq_and_math_registers_core.sv
